// ===== rtl/wsd_pkg.sv =====
// Package for the WebSocket frame deframer: widths, result codes, parser
// states and the result record shared by the block's modules.
// No dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

    // Width of the stored payload length and byte countdown
    localparam int PAYLOAD_LENGTH_BITS = 24;
    // Width of the max_payload register and of the payload_length field
    localparam int MAX_PAYLOAD_BITS    = 24;
    // Width used for the length limit compare
    localparam int CMP_BITS = (PAYLOAD_LENGTH_BITS > MAX_PAYLOAD_BITS) ?
                              PAYLOAD_LENGTH_BITS : MAX_PAYLOAD_BITS;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;   // word index of max_payload
    localparam logic [MAX_PAYLOAD_BITS-1:0] MAX_PAYLOAD_RESET = 24'd65535;

    // Header byte codes
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Parser phases
    typedef enum logic [5:0] {
        PH_FIRST  = 6'b000001,
        PH_SECOND = 6'b000010,
        PH_EXT    = 6'b000100,
        PH_KEY    = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_DROP   = 6'b100000
    } t_phase;

    // One result beat
    typedef struct packed {
        logic [1:0]                  kind;
        logic [3:0]                  opcode;
        logic [MAX_PAYLOAD_BITS-1:0] payload_length;
        logic [7:0]                  data_byte;
        logic                        last;
    } t_result;

endpackage

// ===== rtl/wsd_in_if.sv =====
// Input channel of the WebSocket frame deframer: one received byte per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/wsd_out_if.sv =====
// Result channel of the WebSocket frame deframer.
// Depends on wsd_pkg for the field widths.
`timescale 1ns / 1ps

interface wsd_out_if
    import wsd_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [3:0]                  opcode;
    logic [MAX_PAYLOAD_BITS-1:0] payload_length;
    logic [7:0]                  data_byte;
    logic                        last;

    modport source (output valid, output kind, output opcode, output payload_length,
                    output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input opcode, input payload_length,
                    input data_byte, input last, output ready);
endinterface

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket (RFC 6455) receive-side frame deframer, top level.
// Depends on wsd_pkg, wsd_in_if, wsd_out_if, wsd_cfg, wsd_parser, wsd_skid.
//
// Takes one link byte per beat and parses frames: opcode from the first byte,
// mask flag and 7-bit length from the second (126 and 127 select 2 or 8
// big-endian extended length bytes), then a 4-byte mask key when masked.
// The byte that completes the header yields one header result (kind 0) with
// opcode and length; each payload byte yields an unmasked data result
// (kind 1), last set on the final one. A zero-length frame gives a header
// result with last set. A length above max_payload (APB register at byte
// address 0, reset 65535) gives an error result (kind 2) and the block then
// swallows all input until reset. A beat can be accepted every clock while
// input ready is high; a result is registered into the result register, or
// into the skid stage while that is full and not being read. The result register
// plus a one-entry skid stage decouple the two sides; input ready drops only while both are full.
`timescale 1ns / 1ps

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    wsd_in_if.sink                   i_rx,
    wsd_out_if.source                o_res
);

    logic [MAX_PAYLOAD_BITS-1:0] max_payload;
    logic                        accept;
    logic                        res_valid;
    t_result                     res;
    logic                        skid_ready;
    t_result                     out_data;

    wsd_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_payload (max_payload)
    );

    // input beat handshake
    assign i_rx.ready = skid_ready;
    assign accept     = i_rx.valid && skid_ready;

    wsd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx.rx_byte),
        .i_max_payload (max_payload),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    wsd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_ready (skid_ready),
        .o_valid (o_res.valid),
        .o_data  (out_data),
        .i_ready (o_res.ready)
    );

    // result fields
    assign o_res.kind           = out_data.kind;
    assign o_res.opcode         = out_data.opcode;
    assign o_res.payload_length = out_data.payload_length;
    assign o_res.data_byte      = out_data.data_byte;
    assign o_res.last           = out_data.last;

endmodule

// ===== rtl/wsd_cfg.sv =====
// APB-style configuration register file: holds max_payload.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_cfg
    import wsd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_BITS-1:0]    paddr,
    input  logic [APB_DATA_BITS-1:0]    pwdata,
    output logic [APB_DATA_BITS-1:0]    prdata,
    output logic                        pready,
    output logic [MAX_PAYLOAD_BITS-1:0] o_max_payload
);

    logic [MAX_PAYLOAD_BITS-1:0] r_max_payload;
    logic                        wr_max;

    // word decode: byte offset bits are ignored
    assign wr_max = psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (wr_max) begin
            r_max_payload <= pwdata[MAX_PAYLOAD_BITS-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_PAYLOAD) begin
            prdata = APB_DATA_BITS'(r_max_payload);
        end
    end

    assign pready        = 1'b1;
    assign o_max_payload = r_max_payload;

endmodule

// ===== rtl/wsd_parser.sv =====
// Frame parser: header state machine, length check and payload unmasking.
// Updates its state on each accepted byte and offers at most one result.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_parser
    import wsd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [7:0]                  i_rx_byte,
    input  logic [MAX_PAYLOAD_BITS-1:0] i_max_payload,
    output logic                        o_res_valid,
    output t_result                     o_res
);

    localparam int LB = PAYLOAD_LENGTH_BITS;

    t_phase         r_phase,  n_phase;
    logic [3:0]     r_opcode, n_opcode;
    logic           r_masked, n_masked;
    logic [3:0]     r_hdr,    n_hdr;
    logic [LB-1:0]  r_len,    n_len;
    logic           r_ovf,    n_ovf;     // length has spilled above LB bits
    logic [31:0]    r_key,    n_key;
    logic [LB-1:0]  r_left,   n_left;
    logic [1:0]     r_idx,    n_idx;

    logic           fin;
    logic [LB-1:0]  fin_len;
    logic           fin_ovf;
    logic           too_big;
    logic [7:0]     key_byte;

    // mask key byte for this payload position, first byte on top
    always_comb begin
        case (r_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // next state and result
    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_masked = r_masked;
        n_hdr    = r_hdr;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_key    = r_key;
        n_left   = r_left;
        n_idx    = r_idx;
        fin      = 1'b0;
        fin_len  = r_len;
        fin_ovf  = r_ovf;
        too_big  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.opcode = r_opcode;

        if (i_accept) begin
            unique case (r_phase)
                PH_FIRST: begin
                    n_opcode = i_rx_byte[3:0];
                    n_phase  = PH_SECOND;
                end
                PH_SECOND: begin
                    n_masked = i_rx_byte[7];
                    n_key    = '0;
                    n_idx    = '0;
                    n_len    = '0;
                    n_ovf    = 1'b0;
                    if (i_rx_byte[6:0] == LEN7_EXT16) begin
                        n_hdr   = EXT16_BYTES;
                        n_phase = PH_EXT;
                    end else if (i_rx_byte[6:0] == LEN7_EXT64) begin
                        n_hdr   = EXT64_BYTES;
                        n_phase = PH_EXT;
                    end else begin
                        n_len = LB'(i_rx_byte[6:0]);
                        if (i_rx_byte[7]) begin
                            n_hdr   = KEY_BYTES;
                            n_phase = PH_KEY;
                        end else begin
                            n_hdr   = '0;
                            fin     = 1'b1;
                            fin_len = LB'(i_rx_byte[6:0]);
                            fin_ovf = 1'b0;
                        end
                    end
                end
                PH_EXT: begin
                    // big-endian length, remember anything shifted out the top
                    n_len = {r_len[LB-9:0], i_rx_byte};
                    n_ovf = r_ovf || (|r_len[LB-1:LB-8]);
                    if (r_hdr > 4'd1) begin
                        n_hdr = r_hdr - 4'd1;
                    end else if (r_masked) begin
                        n_hdr   = KEY_BYTES;
                        n_phase = PH_KEY;
                    end else begin
                        n_hdr   = '0;
                        fin     = 1'b1;
                        fin_len = n_len;
                        fin_ovf = n_ovf;
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[23:0], i_rx_byte};
                    if (r_hdr > 4'd1) begin
                        n_hdr = r_hdr - 4'd1;
                    end else begin
                        n_hdr = '0;
                        fin   = 1'b1;
                    end
                end
                PH_DATA: begin
                    n_idx  = r_idx + 2'd1;
                    n_left = r_left - LB'(r_left != '0);
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_PAYLOAD;
                    o_res.data_byte = i_rx_byte ^ key_byte;
                    o_res.last      = (n_left == '0);
                    if (n_left == '0) begin
                        n_phase = PH_FIRST;
                    end
                end
                PH_DROP: begin
                end
                default: begin
                end
            endcase
        end

        // header complete: length check and frame-start result
        if (fin) begin
            too_big     = fin_ovf || (CMP_BITS'(fin_len) > CMP_BITS'(i_max_payload));
            o_res_valid = 1'b1;
            if (too_big) begin
                n_phase    = PH_DROP;
                o_res.kind = KIND_ERROR;
                o_res.last = 1'b1;
            end else begin
                n_left     = fin_len;
                n_idx      = '0;
                o_res.kind = KIND_HEADER;
                if (fin_len == '0) begin
                    n_phase    = PH_FIRST;
                    o_res.last = 1'b1;
                end else begin
                    n_phase              = PH_DATA;
                    o_res.payload_length = MAX_PAYLOAD_BITS'(fin_len);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_opcode <= '0;
            r_masked <= 1'b0;
            r_hdr    <= '0;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_key    <= '0;
            r_left   <= '0;
            r_idx    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_hdr    <= n_hdr;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_key    <= n_key;
            r_left   <= n_left;
            r_idx    <= n_idx;
        end
    end

endmodule

// ===== rtl/wsd_skid.sv =====
// Result register with a skid stage, so the input side keeps taking bytes
// while a result waits. Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_skid
    import wsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_valid) begin
            if (!r_main_valid || pop) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule
